// ----- rtl/pearson_correlation_defines.svh -----
// assertion macros for the checker file of the correlation block
// expects aclk and aresetn in the scope of each use
`ifndef PEARSON_CORRELATION_DEFINES_SVH
`define PEARSON_CORRELATION_DEFINES_SVH

// condition holds on every clock edge out of reset
`define PC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// trigger in one cycle implies the condition in the next
`define PC_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- rtl/pc_pkg.sv -----
// shared constants for the correlation block
// no dependencies
package pc_pkg;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_CONST = 2'd1;
    localparam logic [1:0] STATUS_OVF   = 2'd2;

    localparam int Q_BITS = 15;
    localparam int S_BITS = 16;
    localparam int IDX_W  = 4;

endpackage

// ----- rtl/pc_front.sv -----
// front end: takes sample beats and accumulates count and sums
// depends on pc_pkg; pushes one snapshot per data set into the queue
module pc_front import pc_pkg::*; #(
    parameter int SB          = 16,
    parameter int CW          = 13,
    parameter int MAX_SAMPLES = 4096,
    parameter int SX_W        = 29,
    parameter int SQ_W        = 45,
    parameter int SNAP_W      = 1 + CW + 2 * SX_W + 3 * SQ_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [15:0]       s_x_sample,
    input  logic [15:0]       s_y_sample,
    input  logic              s_last_pair,
    output logic              push_valid,
    input  logic              push_ready,
    output logic [SNAP_W-1:0] push_data
);

    logic [CW-1:0]          count_reg, count_next;
    logic signed [SX_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [SQ_W-1:0] sxy_reg, sxy_next, sxx_reg, sxx_next, syy_reg, syy_next;
    logic                   ovf_reg, ovf_next;
    logic signed [SB-1:0]   xs, ys;
    logic signed [2*SB-1:0] pxy, pxx, pyy;
    logic                   take, full;

    assign xs   = s_x_sample[SB-1:0];
    assign ys   = s_y_sample[SB-1:0];
    assign pxy  = xs * ys;
    assign pxx  = xs * xs;
    assign pyy  = ys * ys;
    assign full = (count_reg == CW'(MAX_SAMPLES));
    assign take = s_valid & s_ready;

    assign s_ready    = push_ready;
    assign push_valid = take & s_last_pair;

    always_comb begin
        count_next = count_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        sxy_next   = sxy_reg;
        sxx_next   = sxx_reg;
        syy_next   = syy_reg;
        ovf_next   = ovf_reg;
        if (full) begin
            ovf_next = 1'b1;
        end else begin
            count_next = count_reg + CW'(1);
            sx_next    = sx_reg + SX_W'(xs);
            sy_next    = sy_reg + SX_W'(ys);
            sxy_next   = sxy_reg + SQ_W'(pxy);
            sxx_next   = sxx_reg + SQ_W'(pxx);
            syy_next   = syy_reg + SQ_W'(pyy);
        end
    end

    assign push_data = {ovf_next, count_next, sx_next, sy_next, sxy_next, sxx_next, syy_next};

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && s_last_pair)) begin
            count_reg <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxy_reg   <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else if (take) begin
            count_reg <= count_next;
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            sxy_reg   <= sxy_next;
            sxx_reg   <= sxx_next;
            syy_reg   <= syy_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

// ----- rtl/pc_fifo.sv -----
// two-entry queue of data-set snapshots between front and back
// depends on pc_pkg only through the shared import style
module pc_fifo import pc_pkg::*; #(
    parameter int W = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_pop,
    output logic [W-1:0] rd_data
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   fill_reg;
    logic         do_wr, do_rd;

    assign wr_ready = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid & wr_ready;
    assign do_rd    = rd_pop & rd_valid;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (do_wr) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_rd) rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule

// ----- rtl/pc_back.sv -----
// back end: forms c, d, e and searches the root and ratio bit by bit
// depends on pc_pkg; one shift-add multiplier shared by every phase; trial squares are combinational
module pc_back import pc_pkg::*; #(
    parameter int CW     = 13,
    parameter int SX_W   = 29,
    parameter int SQ_W   = 45,
    parameter int WIDE   = 152,
    parameter int SNAP_W = 1 + CW + 2 * SX_W + 3 * SQ_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              snap_valid,
    input  logic [SNAP_W-1:0] snap_data,
    output logic              snap_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [15:0]       m_correlation,
    output logic [15:0]       m_r_squared,
    output logic [12:0]       m_pair_count,
    output logic [1:0]        m_status
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_STORE = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    // product phases
    localparam logic [3:0] PH_NSXY = 4'd0;
    localparam logic [3:0] PH_SXSY = 4'd1;
    localparam logic [3:0] PH_NSXX = 4'd2;
    localparam logic [3:0] PH_SXSX = 4'd3;
    localparam logic [3:0] PH_NSYY = 4'd4;
    localparam logic [3:0] PH_SYSY = 4'd5;
    localparam logic [3:0] PH_DE   = 4'd6;
    localparam logic [3:0] PH_CC   = 4'd7;
    localparam logic [3:0] PH_QRY  = 4'd8;
    localparam logic [3:0] PH_SRY  = 4'd9;

    localparam int O_SXX = SQ_W;
    localparam int O_SXY = 2 * SQ_W;
    localparam int O_SY  = 3 * SQ_W;
    localparam int O_SX  = 3 * SQ_W + SX_W;
    localparam int O_N   = 3 * SQ_W + 2 * SX_W;

    state_t            state_reg;
    logic [3:0]        ph_reg;
    logic [IDX_W-1:0]  bit_reg;
    logic [Q_BITS-1:0] q_reg;
    logic [S_BITS-1:0] s_reg;
    logic              bad_reg;
    logic [WIDE-1:0]   acc_reg, mcand_reg, mplier_reg;
    logic [WIDE-1:0]   tmp_reg, c_reg, d_reg, e_reg, de_reg, c2_reg;
    logic [WIDE-1:0]   op_a, op_b, diff, cm, lim_q, lim_s;
    logic [WIDE-1:0]   n_w, sx_w, sy_w, sxy_w, sxx_w, syy_w;
    logic [Q_BITS-1:0] tq;
    logic [S_BITS-1:0] ts;
    logic [2*Q_BITS-1:0] tt;
    logic              d_bad, e_bad, c_neg, out_free;
    logic [15:0]       corr_reg, rsq_reg;
    logic [12:0]       cnt_reg;
    logic [1:0]        status_reg;
    logic              valid_reg;

    assign n_w   = WIDE'(snap_data[O_N +: CW]);
    assign sx_w  = WIDE'($signed(snap_data[O_SX +: SX_W]));
    assign sy_w  = WIDE'($signed(snap_data[O_SY +: SX_W]));
    assign sxy_w = WIDE'($signed(snap_data[O_SXY +: SQ_W]));
    assign sxx_w = WIDE'($signed(snap_data[O_SXX +: SQ_W]));
    assign syy_w = WIDE'($signed(snap_data[0 +: SQ_W]));

    assign tq    = q_reg | (Q_BITS'(1) << bit_reg);
    assign ts    = s_reg | (S_BITS'(1) << bit_reg);
    assign tt    = (2*Q_BITS)'(tq) * (2*Q_BITS)'(tq);
    assign c_neg = c_reg[WIDE-1];
    assign cm    = c_neg ? (WIDE'(0) - c_reg) : c_reg;
    assign lim_q = c2_reg << 30;
    assign lim_s = c2_reg << 16;
    assign diff  = tmp_reg - acc_reg;
    assign d_bad = d_reg[WIDE-1] || (d_reg == '0);
    assign e_bad = diff[WIDE-1] || (diff == '0);
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        case (ph_reg)
            PH_NSXY: begin op_a = n_w;  op_b = sxy_w; end
            PH_SXSY: begin op_a = sx_w; op_b = sy_w;  end
            PH_NSXX: begin op_a = n_w;  op_b = sxx_w; end
            PH_SXSX: begin op_a = sx_w; op_b = sx_w;  end
            PH_NSYY: begin op_a = n_w;  op_b = syy_w; end
            PH_SYSY: begin op_a = sy_w; op_b = sy_w;  end
            PH_DE:   begin op_a = d_reg; op_b = e_reg; end
            PH_CC:   begin op_a = cm;   op_b = cm;    end
            PH_QRY:  begin op_a = de_reg; op_b = WIDE'(tt); end
            PH_SRY:  begin op_a = de_reg; op_b = WIDE'(ts); end
            default: begin op_a = '0;   op_b = '0;    end
        endcase
    end

    assign snap_pop = (state_reg == ST_DONE) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            if (valid_reg && m_ready) valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    ph_reg  <= PH_NSXY;
                    q_reg   <= '0;
                    s_reg   <= '0;
                    bad_reg <= 1'b0;
                    if (snap_valid) state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    mcand_reg  <= op_a;
                    mplier_reg <= op_b;
                    acc_reg    <= '0;
                    state_reg  <= ST_RUN;
                end
                ST_RUN: begin
                    if (mplier_reg == '0) begin
                        state_reg <= ST_STORE;
                    end else begin
                        if (mplier_reg[0]) acc_reg <= acc_reg + mcand_reg;
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                    end
                end
                ST_STORE: begin
                    state_reg <= ST_LOAD;
                    ph_reg    <= ph_reg + 4'd1;
                    case (ph_reg)
                        PH_NSXY, PH_NSXX, PH_NSYY: tmp_reg <= acc_reg;
                        PH_SXSY: c_reg <= diff;
                        PH_SXSX: d_reg <= diff;
                        PH_SYSY: begin
                            e_reg <= diff;
                            if (d_bad || e_bad) begin
                                bad_reg   <= 1'b1;
                                state_reg <= ST_DONE;
                            end
                        end
                        PH_DE: de_reg <= acc_reg;
                        PH_CC: begin
                            c2_reg  <= acc_reg;
                            bit_reg <= IDX_W'(Q_BITS - 1);
                        end
                        PH_QRY: begin
                            if (acc_reg <= lim_q) q_reg <= tq;
                            if (bit_reg == '0) begin
                                bit_reg <= IDX_W'(S_BITS - 1);
                            end else begin
                                bit_reg <= bit_reg - IDX_W'(1);
                                ph_reg  <= ph_reg;
                            end
                        end
                        PH_SRY: begin
                            if (acc_reg <= lim_s) s_reg <= ts;
                            if (bit_reg == '0) begin
                                state_reg <= ST_DONE;
                            end else begin
                                bit_reg <= bit_reg - IDX_W'(1);
                                ph_reg  <= ph_reg;
                            end
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                ST_DONE: begin
                    if (out_free) begin
                        valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result payload, loaded as the beat is handed to the output register
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            corr_reg <= c_neg ? (16'd0 - 16'(q_reg)) : 16'(q_reg);
            rsq_reg  <= s_reg;
            cnt_reg  <= 13'(snap_data[O_N +: CW]);
            if (snap_data[SNAP_W-1]) status_reg <= STATUS_OVF;
            else if (bad_reg)        status_reg <= STATUS_CONST;
            else                     status_reg <= STATUS_OK;
        end
    end

    assign m_valid       = valid_reg;
    assign m_correlation = corr_reg;
    assign m_r_squared   = rsq_reg;
    assign m_pair_count  = cnt_reg;
    assign m_status      = status_reg;

endmodule

// ----- rtl/pearson_correlation.sv -----
// channel | beat                                   | handshake
// s_      | x_sample, y_sample, last_pair          | s_valid / s_ready
// m_      | correlation, r_squared, pair_count, st | m_valid / m_ready
//
// sample beats are taken one per cycle while s_ready is high; sums update in the same cycle
// per data set the back end runs 8 + 15 + 16 shift-add products (6 if d or e <= 0),
// each over WIDE bits at most (WIDE = 152 by default): load, one bit per cycle, end, store
// a two-entry snapshot queue lets the front keep taking beats meanwhile;
// s_ready drops while the queue holds two finished data sets, the one in the back end included
// aresetn is synchronous, active low, and clears all control state
module pearson_correlation import pc_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_SAMPLES = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_x_sample,
    input  logic [15:0] s_y_sample,
    input  logic        s_last_pair,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_correlation,
    output logic [15:0] m_r_squared,
    output logic [12:0] m_pair_count,
    output logic [1:0]  m_status
);

    localparam int SB     = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
    localparam int CW     = $clog2(MAX_SAMPLES + 1);
    localparam int SX_W   = SB + CW;
    localparam int SQ_W   = 2 * SB + CW;
    localparam int CDE_A  = CW + 1 + SQ_W;
    localparam int CDE_W  = ((CDE_A > 2 * SX_W) ? CDE_A : 2 * SX_W) + 1;
    localparam int WIDE   = 2 * CDE_W + 32;
    localparam int SNAP_W = 1 + CW + 2 * SX_W + 3 * SQ_W;

    logic              push_valid, push_ready, snap_valid, snap_pop;
    logic [SNAP_W-1:0] push_data, snap_data;

    pc_front #(
        .SB(SB), .CW(CW), .MAX_SAMPLES(MAX_SAMPLES),
        .SX_W(SX_W), .SQ_W(SQ_W), .SNAP_W(SNAP_W)
    ) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_x_sample, .s_y_sample, .s_last_pair,
        .push_valid, .push_ready, .push_data
    );

    pc_fifo #(.W(SNAP_W)) u_fifo (
        .aclk, .aresetn,
        .wr_valid(push_valid), .wr_ready(push_ready), .wr_data(push_data),
        .rd_valid(snap_valid), .rd_pop(snap_pop), .rd_data(snap_data)
    );

    pc_back #(
        .CW(CW), .SX_W(SX_W), .SQ_W(SQ_W), .WIDE(WIDE), .SNAP_W(SNAP_W)
    ) u_back (
        .aclk, .aresetn, .snap_valid, .snap_data, .snap_pop,
        .m_valid, .m_ready, .m_correlation, .m_r_squared, .m_pair_count, .m_status
    );

endmodule

// ----- rtl/pc_checker.sv -----
// port-level checks for the correlation block, bound to the top level
// depends on pc_pkg and pearson_correlation_defines.svh
`include "pearson_correlation_defines.svh"

module pc_checker import pc_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [15:0] s_x_sample,
    input logic [15:0] s_y_sample,
    input logic        s_last_pair,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_correlation,
    input logic [15:0] m_r_squared,
    input logic [12:0] m_pair_count,
    input logic [1:0]  m_status
);

    `PC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_correlation), "result beat dropped or changed while stalled")
    `PC_ASSERT_ALWAYS(a_status_code, !m_valid || m_status != 2'd3, "undefined status code")
    `PC_ASSERT_ALWAYS(a_count_nonzero, !m_valid || m_pair_count != 13'd0, "result with zero pairs")
    `PC_ASSERT_ALWAYS(a_const_zero, !m_valid || m_status != STATUS_CONST || (m_correlation == 16'd0 && m_r_squared == 16'd0), "constant data with nonzero result")

endmodule

bind pearson_correlation pc_checker u_pc_checker (.*);
